/* hdl/bnks_pkg.sv */
package bnks_pkg;

  localparam int NodeCapacityDef = 16;

  localparam int SlotW  = 5;
  localparam int KeyW   = 32;
  localparam int ChildW = 32;
  localparam int CntW   = 5;
  localparam int PosW   = 5;

  localparam int CfgAddrW = 1;
  localparam int CfgDataW = 5;

  // input tdata: slot, entry_key, entry_child, search_key
  localparam int SlotLsb   = 0;
  localparam int EKeyLsb   = SlotLsb + SlotW;
  localparam int EChildLsb = EKeyLsb + KeyW;
  localparam int SKeyLsb   = EChildLsb + ChildW;
  localparam int InFieldW  = SKeyLsb + KeyW;
  localparam int InDataW   = ((InFieldW + 7) / 8) * 8;

  // output tdata: position, found, child_page, at_end
  localparam int PosLsb    = 0;
  localparam int FoundBit  = PosLsb + PosW;
  localparam int ChildLsb  = FoundBit + 1;
  localparam int AtEndBit  = ChildLsb + ChildW;
  localparam int OutFieldW = AtEndBit + 1;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic KIND_LEAF     = 1'b0;
  localparam logic KIND_INTERNAL = 1'b1;

  localparam logic [CfgAddrW-1:0] REG_NODE_KIND = 1'b0;
  localparam logic [CfgAddrW-1:0] REG_KEY_COUNT = 1'b1;

  typedef struct packed {
    logic wr;
    logic start;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic internal;
  } status_t;

endpackage

/* hdl/bnks_ram.sv */
module bnks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/bnks_ctrl.sv */
module bnks_ctrl import bnks_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_valid_i,
  input  logic    op_i,
  output logic    s_ready_o,
  input  logic    m_ready_i,
  output logic    m_valid_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_CHILD,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   m_valid_q;
  logic   accept;
  logic   out_free;

  assign s_ready_o = (state_q == S_IDLE);
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !m_valid_q || m_ready_i;
  assign m_valid_o = m_valid_q;

  always_comb begin
    cmd_o.wr    = accept && (op_i == OP_WRITE);
    cmd_o.start = accept && (op_i == OP_SEARCH);
    cmd_o.step  = (state_q == S_CMP);
    cmd_o.load  = (state_q == S_FINISH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_ready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept && (op_i == OP_SEARCH)) begin
            state_q <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (status_i.empty) begin
            state_q <= status_i.internal ? S_CHILD : S_FINISH;
          end else begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= status_i.hit ? S_FINISH : S_PROBE;
        end
        S_CHILD: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/bnks_dp.sv */
module bnks_dp import bnks_pkg::*; #(
  parameter int NODE_CAPACITY = NodeCapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic [InDataW-1:0]  in_data_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [OutDataW-1:0] out_data_o
);

  localparam int IdxW = $clog2(NODE_CAPACITY + 1);
  localparam int KAw  = (NODE_CAPACITY > 1) ? $clog2(NODE_CAPACITY) : 1;

  logic                kind_q;
  logic [CntW-1:0]     count_q;
  logic [KeyW-1:0]     skey_q;
  logic [IdxW-1:0]     lo_q, hi_q;
  logic                found_q;
  logic [OutDataW-1:0] out_q;

  logic [SlotW-1:0]    slot;
  logic [KeyW-1:0]     ekey;
  logic [ChildW-1:0]   echild;
  logic [IdxW-1:0]     eff_cnt;
  logic [IdxW-1:0]     mid;
  logic [KeyW-1:0]     key_rdata;
  logic [ChildW-1:0]   child_rdata;
  logic                key_we, child_we;

  assign slot   = in_data_i[SlotLsb +: SlotW];
  assign ekey   = in_data_i[EKeyLsb +: KeyW];
  assign echild = in_data_i[EChildLsb +: ChildW];

  assign key_we   = cmd_i.wr && (32'(slot) < NODE_CAPACITY);
  assign child_we = cmd_i.wr && (32'(slot) <= NODE_CAPACITY);

  assign eff_cnt = (32'(count_q) > NODE_CAPACITY) ? IdxW'(NODE_CAPACITY) : IdxW'(count_q);
  assign mid     = lo_q + ((hi_q - lo_q) >> 1);

  bnks_ram #(
    .WIDTH (KeyW),
    .DEPTH (NODE_CAPACITY)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (KAw'(slot)),
    .wdata_i (ekey),
    .raddr_i (mid[KAw-1:0]),
    .rdata_o (key_rdata)
  );

  bnks_ram #(
    .WIDTH (ChildW),
    .DEPTH (NODE_CAPACITY + 1)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (IdxW'(slot)),
    .wdata_i (echild),
    .raddr_i (lo_q),
    .rdata_o (child_rdata)
  );

  assign status_o.empty    = (lo_q == hi_q);
  assign status_o.hit      = (kind_q == KIND_LEAF) && (skey_q == key_rdata);
  assign status_o.internal = (kind_q == KIND_INTERNAL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_LEAF;
      count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_NODE_KIND: kind_q  <= cfg_wdata_i[0];
        REG_KEY_COUNT: count_q <= cfg_wdata_i;
        default:       kind_q  <= kind_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      skey_q  <= in_data_i[SKeyLsb +: KeyW];
      lo_q    <= '0;
      hi_q    <= eff_cnt;
      found_q <= 1'b0;
    end else if (cmd_i.step) begin
      priority if (status_o.hit) begin
        lo_q    <= mid;
        found_q <= 1'b1;
      end else if (key_rdata >= skey_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= IdxW'(mid + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_q <= OutDataW'({(lo_q == eff_cnt),
                          (kind_q == KIND_INTERNAL) ? child_rdata : {ChildW{1'b0}},
                          found_q,
                          PosW'(lo_q)});
    end
  end

  assign out_data_o = out_q;

endmodule

/* hdl/btree_node_key_search.sv */
// B-tree node key search. The block holds one node of up to NODE_CAPACITY sorted 32-bit
// keys and NODE_CAPACITY+1 child page numbers. An input transfer with tuser low writes
// the key and child at slot (slot NODE_CAPACITY takes only the child, higher slots are
// dropped) and gives no result. With tuser high it runs a binary search over the first
// key_count keys and returns one result transfer: leaf nodes report an exact match or the
// insertion point, internal nodes report the first key not below the search key and its
// child page. Each probe passes through a probe and a compare state because the key memory
// has a registered read; there are at most 5 probes for 16 keys. A leaf search stops on an
// equal key, an internal node adds a state that reads the child page, and the block stays
// busy while the previous result still waits in the output register.
// A finished result sits in the output register while the next item is taken.
// Write node_kind and key_count only while the block is idle.
module btree_node_key_search import bnks_pkg::*; #(
  parameter int NODE_CAPACITY = NodeCapacityDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // slot, entry_key, entry_child, search_key
  input  logic [InDataW-1:0]  s_axis_tdata,
  // op
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // position, found, child_page, at_end
  output logic [OutDataW-1:0] m_axis_tdata
);

  cmd_t    cmd;
  status_t status;

  bnks_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .op_i      (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  bnks_dp #(
    .NODE_CAPACITY (NODE_CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

endmodule

/* hdl/bnks_checker.sv */
module bnks_checker import bnks_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgAddrW-1:0] cfg_addr_i,
  input logic [CfgDataW-1:0] cfg_wdata_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [InDataW-1:0]  s_axis_tdata,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a search keeps the input closed in the next cycle
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == OP_SEARCH) |=> !s_axis_tready)
    else $error("input open right after a search transfer");

  // a write finishes at once
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (s_axis_tuser == OP_WRITE) |=> s_axis_tready)
    else $error("input closed after a write transfer");

  // a hit lies inside the key range
  a_found_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FoundBit] |-> !m_axis_tdata[AtEndBit])
    else $error("found and at_end both set");

  // a hit only comes from a leaf search, which has no child
  a_found_no_child: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[FoundBit] |-> (m_axis_tdata[ChildLsb +: ChildW] == '0))
    else $error("child page set on a leaf hit");

endmodule

bind btree_node_key_search bnks_checker u_bnks_checker (.*);
